FILE: hw/rtl/i2cmbe_pkg.sv
// shared types and command codes for the i2c master bit engine
package i2cmbe_pkg;

   // active operation, numbered as the command codes on req_cmd
   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   localparam int unsigned PHASE_W = 6;

   // last phases of the start and stop sequences, and the bit-end and ack-high phases of write and read
   localparam logic [PHASE_W-1:0] START_LAST_PH = 6'd4;
   localparam logic [PHASE_W-1:0] STOP_LAST_PH  = 6'd2;
   localparam logic [PHASE_W-1:0] BITS_END_PH   = 6'd16;
   localparam logic [PHASE_W-1:0] ACK_HIGH_PH   = 6'd17;

   // one result beat
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_seen;
   } rsp_type;

endpackage

FILE: hw/rtl/i2cmbe_sequencer.sv
// phase sequencer: bus state registers and the per-tick next-state logic
module i2cmbe_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [2:0]            cmd,
   input  logic [7:0]            tx_byte,
   input  logic                  ack_to_send,
   input  logic                  sda_in,
   output i2cmbe_pkg::rsp_type   res
);

   logic [i2cmbe_pkg::PHASE_W-1:0] phase_ff, phase_in;
   i2cmbe_pkg::op_type             op_ff, op_in;
   logic [7:0]                     shift_ff, shift_in;
   logic                           scl_ff, scl_in;
   logic                           sda_ff, sda_in_n;
   logic                           ack_ff, ack_in;
   logic [7:0]                     rx_ff, rx_in;
   logic                           ack_send_ff, ack_send_in;

   logic [i2cmbe_pkg::PHASE_W-1:0] ph;
   i2cmbe_pkg::op_type             op;
   logic                           last;
   logic                           new_cmd;

   always_comb begin
      op          = op_ff;
      ph          = phase_ff;
      shift_in    = shift_ff;
      scl_in      = scl_ff;
      sda_in_n    = sda_ff;
      ack_in      = ack_ff;
      rx_in       = rx_ff;
      ack_send_in = ack_send_ff;
      last        = 1'b0;
      new_cmd     = (op_ff == i2cmbe_pkg::OP_IDLE)
                    && (cmd >= 3'(i2cmbe_pkg::OP_START))
                    && (cmd <= 3'(i2cmbe_pkg::OP_READ));

      // command is taken only while idle
      if (new_cmd) begin
         op = i2cmbe_pkg::op_type'(cmd);
         ph = '0;
         if (op == i2cmbe_pkg::OP_START && sda_in)
            ph = i2cmbe_pkg::PHASE_W'(1);
         if (op == i2cmbe_pkg::OP_WRITE)
            shift_in = tx_byte;
         if (op == i2cmbe_pkg::OP_READ) begin
            shift_in    = '0;
            ack_send_in = ack_to_send;
         end
      end

      unique case (op)
         i2cmbe_pkg::OP_IDLE: begin
            last = 1'b0;
         end
         i2cmbe_pkg::OP_START: begin
            unique case (ph)
               6'd0: scl_in = 1'b0;
               6'd1: sda_in_n = 1'b1;
               6'd2: scl_in = 1'b1;
               6'd3: sda_in_n = 1'b0;
               default: begin
                  scl_in = 1'b0;
                  last   = 1'b1;
               end
            endcase
         end
         i2cmbe_pkg::OP_STOP: begin
            unique case (ph)
               6'd0: sda_in_n = 1'b0;
               6'd1: scl_in = 1'b1;
               default: begin
                  sda_in_n = 1'b1;
                  last     = 1'b1;
               end
            endcase
         end
         i2cmbe_pkg::OP_WRITE: begin
            priority if (ph < i2cmbe_pkg::BITS_END_PH) begin
               if (!ph[0]) begin
                  if (ph != '0) scl_in = 1'b0;
                  // msb first: bit index is 7 minus the bit count
                  sda_in_n = shift_in[~ph[3:1]];
               end else begin
                  scl_in = 1'b1;
               end
            end else if (ph == i2cmbe_pkg::BITS_END_PH) begin
               scl_in   = 1'b0;
               sda_in_n = 1'b1;
            end else if (ph == i2cmbe_pkg::ACK_HIGH_PH) begin
               scl_in = 1'b1;
            end else begin
               ack_in = sda_in;
               scl_in = 1'b0;
               last   = 1'b1;
            end
         end
         i2cmbe_pkg::OP_READ: begin
            priority if (ph == '0) begin
               sda_in_n = 1'b1;
            end else if (ph <= i2cmbe_pkg::BITS_END_PH) begin
               if (ph[0]) begin
                  scl_in = 1'b1;
               end else begin
                  shift_in = {shift_in[6:0], sda_in};
                  scl_in   = 1'b0;
                  if (ph == i2cmbe_pkg::BITS_END_PH) sda_in_n = ack_send_in;
               end
            end else if (ph == i2cmbe_pkg::ACK_HIGH_PH) begin
               scl_in = 1'b1;
            end else begin
               scl_in   = 1'b0;
               sda_in_n = 1'b1;
               rx_in    = shift_in;
               last     = 1'b1;
            end
         end
         default: begin
            last = 1'b1;
         end
      endcase

      if (op == i2cmbe_pkg::OP_IDLE) begin
         op_in    = op;
         phase_in = ph;
      end else if (last) begin
         op_in    = i2cmbe_pkg::OP_IDLE;
         phase_in = '0;
      end else begin
         op_in    = op;
         phase_in = ph + i2cmbe_pkg::PHASE_W'(1);
      end

      res.scl_level = scl_in;
      res.sda_level = sda_in_n;
      res.busy_res  = (op != i2cmbe_pkg::OP_IDLE) && !last;
      res.done_res  = (op != i2cmbe_pkg::OP_IDLE) && last;
      res.rx_byte   = rx_in;
      res.ack_seen  = ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         op_ff       <= i2cmbe_pkg::OP_IDLE;
         shift_ff    <= '0;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
         ack_ff      <= 1'b1;
         rx_ff       <= '0;
         ack_send_ff <= 1'b1;
      end else if (fire) begin
         phase_ff    <= phase_in;
         op_ff       <= op_in;
         shift_ff    <= shift_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in_n;
         ack_ff      <= ack_in;
         rx_ff       <= rx_in;
         ack_send_ff <= ack_send_in;
      end
   end

   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(res.busy_res && res.done_res))
      else $error("busy and done together");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      fire && res.done_res |=> op_ff == i2cmbe_pkg::OP_IDLE)
      else $error("sequence did not return to idle after done");

   a_idle_phase_zero: assert property (@(posedge clock) disable iff (reset)
      op_ff == i2cmbe_pkg::OP_IDLE |-> phase_ff == '0)
      else $error("phase count not cleared while idle");

   a_active_reports: assert property (@(posedge clock) disable iff (reset)
      op_ff != i2cmbe_pkg::OP_IDLE |-> (res.busy_res || res.done_res))
      else $error("active sequence reported neither busy nor done");

endmodule

FILE: hw/rtl/i2cmbe_out_stage.sv
// result register with valid/ready handshake
module i2cmbe_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  i2cmbe_pkg::rsp_type   res,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output i2cmbe_pkg::rsp_type   rsp_data
);

   logic                valid_ff;
   i2cmbe_pkg::rsp_type data_ff;

   // slot can take a new beat when empty or being drained this cycle
   assign free      = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

endmodule

FILE: hw/rtl/i2c_master_bit_engine.sv
// i2c master bit engine top: input register, phase sequencer, result register
// a beat accepted on req_ passes the input register, then the sequencer and result register, to rsp_
// throughput: one tick per cycle while the result slot drains, the sequencer advances one bus phase per beat
// a new req_ beat is taken while a result waits, as long as the result slot drains
// reset (synchronous, active high) empties both registers, idles the sequencer,
// releases scl and sda, sets the ack flag to one and clears the received byte
module i2c_master_bit_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_tx_byte,
   input  logic       req_ack_to_send,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_ack_seen
);

   logic                in_valid_ff;
   logic [2:0]          cmd_ff;
   logic [7:0]          tx_byte_ff;
   logic                ack_to_send_ff;
   logic                sda_ff;
   logic                out_free;
   logic                fire;
   i2cmbe_pkg::rsp_type res;
   i2cmbe_pkg::rsp_type rsp_data;

   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff         <= req_cmd;
         tx_byte_ff     <= req_tx_byte;
         ack_to_send_ff <= req_ack_to_send;
         sda_ff         <= req_sda_in;
      end
   end

   i2cmbe_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .cmd         (cmd_ff),
      .tx_byte     (tx_byte_ff),
      .ack_to_send (ack_to_send_ff),
      .sda_in      (sda_ff),
      .res         (res)
   );

   i2cmbe_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .res       (res),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_scl_level = rsp_data.scl_level;
   assign rsp_sda_level = rsp_data.sda_level;
   assign rsp_busy_res  = rsp_data.busy_res;
   assign rsp_done_res  = rsp_data.done_res;
   assign rsp_rx_byte   = rsp_data.rx_byte;
   assign rsp_ack_seen  = rsp_data.ack_seen;

endmodule
